// ===== hdl/fwvs_pkg.sv =====
`default_nettype none
package fwvs_pkg;
  localparam int SLOTS_PER_KIND = 4;
  localparam int MUSIC_SLOTS_DEF = 2;
  localparam int PHASE_W = 26;
  localparam int VOL_W = 32;
  localparam int ACC_W = 48;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_SET = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VOICE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic write_voice;
    logic voice_clear;
    logic voice_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic voice_last;
    logic out_busy;
  } status_t;

  // duty thresholds on phase[25:23], the top three bits
  function automatic logic [2:0] duty_limit(input logic [1:0] d);
    case (d)
      2'd0: duty_limit = 3'd1;
      2'd1: duty_limit = 3'd2;
      2'd2: duty_limit = 3'd4;
      default: duty_limit = 3'd6;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== hdl/fwvs_ctrl.sv =====
`default_nettype none
module fwvs_ctrl
  import fwvs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic [1:0] op,
  output logic           in_ready,
  input  status_t        status,
  output cmd_t           cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !status.out_busy;
        if (in_valid && !status.out_busy) begin
          cmd.load = 1'b1;
          if (op == OP_TICK) begin
            cmd.voice_clear = 1'b1;
            state_next = ST_VOICE;
          end else if (op == OP_PLAY) begin
            cmd.scan_clear = 1'b1;
            state_next = ST_SCAN;
          end else if (op == OP_SET) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.write_voice = 1'b1;
        state_next = ST_IDLE;
      end
      ST_VOICE: begin
        cmd.voice_step = 1'b1;
        if (status.voice_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/fwvs_datapath.sv =====
`default_nettype none
module fwvs_datapath
  import fwvs_pkg::*;
#(
  parameter int MUSIC_SLOTS = MUSIC_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [1:0]  op,
  input  wire logic [1:0]  waveform,
  input  wire logic        music_slot,
  input  wire logic [19:0] pitch,
  input  wire logic [1:0]  duty,
  input  wire logic [15:0] volume,
  input  wire logic [19:0] fade,
  input  wire logic [31:0] noise_seed,
  input  wire logic        noise_short,
  input  wire logic [15:0] noise_period,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      sample,
  output logic [4:0]       active_voices
);
  localparam int NV = 4 * SLOTS_PER_KIND;
  localparam int SW = $clog2(SLOTS_PER_KIND);
  localparam int VW = $clog2(NV);
  localparam int SHIFT = 17 + $clog2(NV);
  localparam bit HAS_FX = MUSIC_SLOTS < SLOTS_PER_KIND;

  logic [17:0] sample_rate;
  logic [31:0] inverse_rate;
  logic [NV-1:0] vactive;
  logic [VOL_W-1:0] vvol [NV];
  logic [19:0] vfade [NV];
  logic [19:0] vpitch [NV];
  logic [PHASE_W-1:0] vphase [NV];
  logic [1:0] sduty [SLOTS_PER_KIND];
  logic [31:0] nreg [SLOTS_PER_KIND];
  logic ntap [SLOTS_PER_KIND];
  logic [15:0] nint [SLOTS_PER_KIND];
  logic [15:0] ndiv [SLOTS_PER_KIND];
  logic [17:0] sample_time;

  // latched request
  logic [1:0] r_op, r_kind;
  logic r_mslot;
  logic [19:0] r_pitch, r_fade;
  logic [1:0] r_duty;
  logic [15:0] r_vol, r_period;
  logic [31:0] r_seed;
  logic r_short;

  logic [SW:0] scan_i;
  logic [SW-1:0] pick;
  logic [VOL_W-1:0] maxv;
  logic found;
  logic [VW:0] vi;
  logic signed [ACC_W-1:0] acc;
  logic [4:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= 18'd48000;
      inverse_rate <= 32'd89478;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) sample_rate <= cfg_data[17:0];
      else inverse_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_op <= op; r_kind <= waveform; r_mslot <= music_slot;
      r_pitch <= pitch; r_fade <= fade; r_duty <= duty; r_vol <= volume;
      r_period <= noise_period; r_seed <= noise_seed; r_short <= noise_short;
    end
  end

  // effect slot search, one slot a cycle
  logic [VW-1:0] scan_v;
  assign scan_v = VW'({r_kind, {SW{1'b0}}} | VW'(scan_i[SW-1:0]));
  assign status.scan_last = found || (scan_i >= (SW+1)'(SLOTS_PER_KIND - 1));
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_i <= (SW+1)'(MUSIC_SLOTS);
      pick <= SW'(MUSIC_SLOTS);
      maxv <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step && !found) begin
      if (!vactive[scan_v]) begin
        pick <= scan_i[SW-1:0];
        found <= 1'b1;
      end else if (vvol[scan_v] > maxv) begin
        maxv <= vvol[scan_v];
        pick <= scan_i[SW-1:0];
      end
      scan_i <= scan_i + 1'b1;
    end
  end

  logic [SW-1:0] wslot;
  logic wen;
  assign wslot = (r_op == OP_PLAY) ? pick : SW'(r_mslot);
  assign wen = cmd.write_voice &&
               ((r_op == OP_PLAY) ? HAS_FX : (32'(r_mslot) < MUSIC_SLOTS));
  logic [VW-1:0] wv;
  assign wv = VW'({r_kind, {SW{1'b0}}} | VW'(wslot));

  // per-voice tick datapath, one voice a cycle
  logic [VW-1:0] cv;
  logic [1:0] ck;
  logic [SW-1:0] cs;
  assign cv = vi[VW-1:0];
  assign ck = cv[VW-1 -: 2];
  assign cs = cv[SW-1:0];
  assign status.voice_last = (vi == (VW+1)'(NV - 1));

  logic [PHASE_W-1:0] ph;
  logic [31:0] nr;
  logic signed [17:0] wave;
  logic [16:0] tri_x;
  logic [16:0] nq;
  assign ph = vphase[cv];
  assign nr = nreg[cs];
  assign tri_x = ph[23:7];
  // (x << 16) / 255 for an 8-bit x is x * 257, plus one when x is 255
  assign nq = {1'b0, nr[7:0], nr[7:0]} + {16'd0, nr[7:0] == 8'hFF};
  always_comb begin
    case (ck)
      2'd0: wave = ({1'b0, ph[25:23]} & 4'd7) < {1'b0, duty_limit(sduty[cs])} ?
                   18'sd32768 : -18'sd32768;
      2'd1: wave = $signed({1'b0, nq});
      2'd2: wave = (tri_x < 17'd65536) ? $signed({1'b0, tri_x}) - 18'sd32768
                                        : 18'sd98304 - $signed({1'b0, tri_x});
      default: wave = $signed({2'b0, ph[23:8]}) - 18'sd32768;
    endcase
  end

  logic signed [34:0] prod;
  logic [51:0] fprod, pprod;
  logic [35:0] dec;
  logic [PHASE_W-1:0] pstep;
  logic dies;
  assign prod = wave * $signed({1'b0, vvol[cv][31:16]});
  assign fprod = vfade[cv] * inverse_rate;
  assign pprod = vpitch[cv] * inverse_rate;
  assign dec = fprod[51:16];
  assign pstep = pprod[12 +: PHASE_W];
  assign dies = {4'd0, vvol[cv]} <= dec;

  logic [15:0] nperiod;
  logic [15:0] dnext;
  logic [31:0] rr;
  logic fb;
  assign nperiod = (nint[cs] == 16'd0) ? 16'd1 : nint[cs];
  assign dnext = (ndiv[cs] + 16'd1 >= nperiod) ? 16'd0 : ndiv[cs] + 16'd1;
  assign rr = (nr == 32'd0) ? 32'hFFFFFFFF : nr;
  assign fb = ntap[cs] ? (rr[15] ^ rr[14]) : (rr[31] ^ rr[30]);

  logic [17:0] st_inc;
  logic wrap;
  assign st_inc = sample_time + 18'd1;
  assign wrap = st_inc >= sample_rate;

  logic signed [ACC_W-1:0] acc_fin;
  logic signed [ACC_W-1:0] q;
  assign acc_fin = acc + ((vactive[cv]) ? ACC_W'(prod) : '0);
  assign q = acc_fin >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      vactive <= '0;
      sample_time <= '0;
      for (int i = 0; i < NV; i++) vphase[i] <= '0;
      for (int i = 0; i < SLOTS_PER_KIND; i++) ndiv[i] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (wen) begin
        vactive[wv] <= 1'b1;
        vvol[wv] <= {r_vol, 16'd0};
        vfade[wv] <= r_fade;
        vpitch[wv] <= r_pitch;
        vphase[wv] <= '0;
        if (r_kind == 2'd0) sduty[wslot] <= r_duty;
        if (r_kind == 2'd1) begin
          nreg[wslot] <= r_seed;
          ntap[wslot] <= r_short;
          nint[wslot] <= r_period;
          ndiv[wslot] <= '0;
        end
      end
      if (cmd.voice_clear) begin
        vi <= '0;
        acc <= '0;
        count <= '0;
      end else if (cmd.voice_step) begin
        vi <= vi + 1'b1;
        if (vactive[cv]) begin
          acc <= acc_fin;
          if (ck == 2'd1) begin
            if (ndiv[cs] == 16'd0) nreg[cs] <= {rr[30:0], fb};
            ndiv[cs] <= dnext;
          end
          if (dies) vactive[cv] <= 1'b0;
          else begin
            vvol[cv] <= vvol[cv] - dec[31:0];
            count <= count + 5'd1;
          end
          // a wrapping last voice has its phase cleared below
          if (!(cmd.finish && wrap)) vphase[cv] <= ph + pstep;
        end
        if (cmd.finish) begin
          out_valid <= 1'b1;
          if (q > 48'sd32767) sample <= 16'h7FFF;
          else if (q < -48'sd32768) sample <= 16'h8000;
          else sample <= q[15:0];
          active_voices <= (vactive[cv] && !dies) ? count + 5'd1 : count;
          sample_time <= wrap ? 18'd0 : st_inc;
          if (wrap) for (int i = 0; i < NV; i++) vphase[i] <= '0;
        end
      end
    end
  end

  assign status.out_busy = out_valid;
endmodule
`default_nettype wire

// ===== hdl/four_waveform_voice_synthesizer.sv =====
// Sixteen-voice synthesizer (four each of square, noise, triangle, sawtooth).
// One item is taken at a time. A tick walks the voices one per cycle through
// a shared wave/volume/phase unit. A play request searches effect slots one
// per cycle. A new item is held off while a sample waits on the output.
`default_nettype none
module four_waveform_voice_synthesizer
  import fwvs_pkg::*;
#(
  parameter int MUSIC_SLOTS = MUSIC_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // operation, waveform, music_slot, pitch, duty, volume, fade, noise_seed,
  // noise_short, noise_period
  input  wire logic [111:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // sample, active_voices, zero fill
  output logic [23:0]       m_tdata
);
  cmd_t cmd;
  status_t status;
  logic [15:0] sample;
  logic [4:0] active_voices;

  fwvs_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .op(s_tdata[1:0]),
    .in_ready(s_tready), .status, .cmd
  );

  fwvs_datapath #(.MUSIC_SLOTS(MUSIC_SLOTS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .op(s_tdata[1:0]), .waveform(s_tdata[3:2]), .music_slot(s_tdata[4]),
    .pitch(s_tdata[24:5]), .duty(s_tdata[26:25]), .volume(s_tdata[42:27]),
    .fade(s_tdata[62:43]), .noise_seed(s_tdata[94:63]), .noise_short(s_tdata[95]),
    .noise_period(s_tdata[111:96]), .cmd, .status,
    .out_valid(m_tvalid), .out_ready(m_tready), .sample, .active_voices
  );

  assign m_tdata = {3'd0, active_voices, sample};
endmodule
`default_nettype wire

// ===== hdl/fwvs_checker.sv =====
`default_nettype none
module fwvs_checker
  import fwvs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_op,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output not held");
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[20:16] <= 5'd16) else $error("voice count too large");
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while output pending");
  // an ignored operation leaves the block idle
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_op != OP_NONE) |=> !s_tready)
    else $error("back to back accept");
endmodule

bind four_waveform_voice_synthesizer fwvs_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .s_op(s_tdata[1:0]), .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// ===== verif/four_waveform_voice_synthesizer_tb.sv =====
`timescale 1ns / 1ps
module four_waveform_voice_synthesizer_tb;
  import fwvs_pkg::*;

  localparam int KIND_SLOTS = 4;
  localparam int MUSIC = 2;
  localparam int VOICES = 4 * KIND_SLOTS;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] KIND_SQUARE = 2'd0;
  localparam logic [1:0] KIND_NOISE = 2'd1;
  localparam logic [1:0] KIND_TRIANGLE = 2'd2;
  localparam logic [1:0] KIND_SAW = 2'd3;
  localparam logic REG_SAMPLE_RATE = 1'b0;
  localparam logic REG_INVERSE_RATE = 1'b1;

  typedef struct packed {
    logic signed [15:0] smp;
    logic [4:0] voices;
  } mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;

  four_waveform_voice_synthesizer dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // synthesizer state as predicted
  logic [17:0] rate_q = 18'd48000;
  logic [31:0] inv_rate_q = 32'd89478;
  bit voice_on [VOICES];
  logic [31:0] voice_vol [VOICES];
  logic [19:0] voice_fd [VOICES];
  logic [19:0] voice_pt [VOICES];
  logic [25:0] voice_ph [VOICES];
  logic [1:0] sq_duty [KIND_SLOTS];
  logic [31:0] lfsr [KIND_SLOTS];
  bit lfsr_short [KIND_SLOTS];
  logic [15:0] lfsr_period [KIND_SLOTS];
  logic [15:0] lfsr_div [KIND_SLOTS];
  logic [17:0] sample_count = '0;

  logic [111:0] pending_items[$];
  mix_t expected_mix[$];
  bit in_fire = 1'b0;
  bit no_gaps = 1'b0;
  int errors = 0;
  int idle_cycles = 0;

  initial begin
    for (int i = 0; i < VOICES; i++) begin
      voice_on[i] = 1'b0;
      voice_ph[i] = '0;
    end
    for (int i = 0; i < KIND_SLOTS; i++) lfsr_div[i] = '0;
  end

  task automatic load_voice(input logic [1:0] kind, input int slot, input logic [111:0] it);
    int v;
    v = kind * KIND_SLOTS + slot;
    voice_on[v] = 1'b1;
    voice_vol[v] = {it[42:27], 16'd0};
    voice_fd[v] = it[62:43];
    voice_pt[v] = it[24:5];
    voice_ph[v] = '0;
    if (kind == KIND_SQUARE) sq_duty[slot] = it[26:25];
    if (kind == KIND_NOISE) begin
      lfsr[slot] = it[94:63];
      lfsr_short[slot] = it[95];
      lfsr_period[slot] = it[111:96];
      lfsr_div[slot] = '0;
    end
  endtask

  function automatic longint wave_level(input int kind, input int slot, input logic [25:0] ph);
    longint x;
    case (kind)
      KIND_SQUARE: return (ph[25:23] < duty_limit(sq_duty[slot])) ? 32768 : -32768;
      KIND_NOISE: return ((longint'(lfsr[slot][7:0])) << 16) / 255;
      KIND_TRIANGLE: begin
        x = longint'(ph[23:0]) << 1 >> 8;
        return (x < 65536) ? x - 32768 : 98304 - x;
      end
      default: return longint'(ph[23:8]) - 32768;
    endcase
  endfunction

  task automatic advance_lfsr(input int s);
    logic [31:0] r;
    logic fb;
    logic [15:0] nxt;
    if (lfsr_div[s] == 0) begin
      r = (lfsr[s] == 0) ? 32'hFFFF_FFFF : lfsr[s];
      fb = lfsr_short[s] ? (r[15] ^ r[14]) : (r[31] ^ r[30]);
      lfsr[s] = {r[30:0], fb};
    end
    nxt = lfsr_div[s] + 16'd1;
    if (lfsr_div[s] == 16'hFFFF || nxt >= ((lfsr_period[s] == 0) ? 16'd1 : lfsr_period[s]))
      nxt = '0;
    lfsr_div[s] = nxt;
  endtask

  // applies one accepted item; a tick queues the mixed sample it should produce
  task automatic synth_apply(input logic [111:0] it);
    op_t op;
    logic [1:0] kind;
    int pick, v;
    bit found;
    logic [31:0] loudest;
    longint mix_sum, q;
    logic [63:0] dec;
    int live;
    mix_t r;
    op = op_t'(it[1:0]);
    kind = it[3:2];
    case (op)
      OP_PLAY: begin
        pick = MUSIC;
        found = 1'b0;
        loudest = '0;
        for (int i = MUSIC; i < KIND_SLOTS; i++) begin
          v = kind * KIND_SLOTS + i;
          if (!found) begin
            if (!voice_on[v]) begin
              pick = i;
              found = 1'b1;
            end else if (voice_vol[v] > loudest) begin
              loudest = voice_vol[v];
              pick = i;
            end
          end
        end
        load_voice(kind, pick, it);
      end
      OP_SET: load_voice(kind, int'(it[4]), it);
      OP_TICK: begin
        mix_sum = 0;
        live = 0;
        for (int k = 0; k < 4; k++) begin
          for (int s = 0; s < KIND_SLOTS; s++) begin
            v = k * KIND_SLOTS + s;
            if (voice_on[v]) begin
              mix_sum += wave_level(k, s, voice_ph[v]) * longint'(voice_vol[v][31:16]);
              if (k == KIND_NOISE) advance_lfsr(s);
              dec = (64'(voice_fd[v]) * 64'(inv_rate_q)) >> 16;
              if (64'(voice_vol[v]) <= dec) voice_on[v] = 1'b0;
              else voice_vol[v] = voice_vol[v] - dec[31:0];
              voice_ph[v] = voice_ph[v] + 26'((64'(voice_pt[v]) * 64'(inv_rate_q)) >> 12);
              if (voice_on[v]) live++;
            end
          end
        end
        q = mix_sum >>> 21;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        sample_count = sample_count + 18'd1;
        if (sample_count >= rate_q) begin
          sample_count = '0;
          for (int i = 0; i < VOICES; i++) voice_ph[i] = '0;
        end
        r.smp = q[15:0];
        r.voices = live[4:0];
        expected_mix.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic logic [111:0] make_item(input op_t op, input logic [1:0] kind,
      input logic slot, input logic [19:0] pitch, input logic [1:0] duty,
      input logic [15:0] vol, input logic [19:0] fade, input logic [31:0] seed,
      input logic nshort, input logic [15:0] period);
    return {period, nshort, seed, fade, vol, duty, pitch, slot, kind, op};
  endfunction

  function automatic logic [111:0] random_item();
    int pct;
    op_t op;
    logic [15:0] vol;
    logic [19:0] fade;
    logic [15:0] period;
    pct = $urandom_range(99);
    if (pct < 58) op = OP_TICK;
    else if (pct < 83) op = OP_PLAY;
    else if (pct < 97) op = OP_SET;
    else op = OP_NONE;
    vol = ($urandom_range(7) == 0) ? 16'(($urandom_range(3) == 0) ? 0 : 16'hFFFF)
                                    : 16'($urandom);
    fade = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(4095));
    period = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    return make_item(op, 2'($urandom), 1'($urandom), 20'($urandom), 2'($urandom), vol, fade,
                     ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom), 1'($urandom), period);
  endfunction

  // driver: next item presented at the falling edge
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_fire) begin
        if (pending_items.size() != 0 && (no_gaps || $urandom_range(99) >= 10)) begin
          s_tdata <= pending_items.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= no_gaps || $urandom_range(99) >= 10;
    end
  end

  // monitor: transfers sampled at the rising edge
  always @(posedge clk) begin
    mix_t got, want;
    in_fire <= s_tvalid && s_tready && !rst;
    if (!rst && s_tvalid && s_tready) synth_apply(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      got.smp = m_tdata[15:0];
      got.voices = m_tdata[20:16];
      if (expected_mix.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample transfer: sample=%0d voices=%0d",
                                   got.smp, got.voices);
      end else begin
        want = expected_mix.pop_front();
        if (got.smp !== want.smp || got.voices !== want.voices) begin
          errors++;
          if (errors <= 10)
            $display("sample mismatch: expected sample=%0d voices=%0d, got sample=%0d voices=%0d",
                     want.smp, want.voices, got.smp, got.voices);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || s_tvalid || expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rates(input logic [17:0] rate, input logic [31:0] inv);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_data <= 32'(rate);
    @(negedge clk);
    cfg_index <= REG_INVERSE_RATE;
    cfg_data <= inv;
    @(negedge clk);
    cfg_we <= 1'b0;
    rate_q = rate;
    inv_rate_q = inv;
  endtask

  task automatic add_random(input int n);
    repeat (n) pending_items.push_back(random_item());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_rates(18'd48000, 32'd89478);

    // music slots with field extremes, each kind
    pending_items.push_back(make_item(OP_SET, KIND_SQUARE, 1'b0, 20'hFFFFF, 2'd0, 16'hFFFF,
                                      20'd0, 32'd0, 1'b0, 16'd0));
    pending_items.push_back(make_item(OP_SET, KIND_SQUARE, 1'b1, 20'd0, 2'd3, 16'h8000,
                                      20'hFFFFF, 32'd0, 1'b0, 16'd0));
    pending_items.push_back(make_item(OP_SET, KIND_NOISE, 1'b0, 20'd1000, 2'd0, 16'hFFFF,
                                      20'd10, 32'd0, 1'b1, 16'd0));
    pending_items.push_back(make_item(OP_SET, KIND_NOISE, 1'b1, 20'd1000, 2'd0, 16'h7FFF,
                                      20'd10, 32'hFFFF_FFFF, 1'b0, 16'hFFFF));
    pending_items.push_back(make_item(OP_SET, KIND_TRIANGLE, 1'b0, 20'h12345, 2'd1, 16'hFFFF,
                                      20'd100, 32'd0, 1'b0, 16'd0));
    pending_items.push_back(make_item(OP_SET, KIND_SAW, 1'b1, 20'h54321, 2'd2, 16'hFFFF,
                                      20'd100, 32'd0, 1'b0, 16'd0));
    pending_items.push_back(make_item(OP_TICK, 2'd0, 1'b0, '0, '0, '0, '0, '0, 1'b0, '0));
    pending_items.push_back(make_item(OP_TICK, 2'd0, 1'b0, '0, '0, '0, '0, '0, 1'b0, '0));
    // all effect slots silent with no tick between: first one is taken again
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(OP_PLAY, KIND_SAW, 1'b0, 20'd880, 2'd0, 16'd0,
                                        20'd5, '0, 1'b0, '0));
    pending_items.push_back(make_item(OP_TICK, 2'd0, 1'b0, '0, '0, '0, '0, '0, 1'b0, '0));
    // fill effect slots then steal the loudest
    for (int i = 0; i < 3; i++)
      pending_items.push_back(make_item(OP_PLAY, KIND_SQUARE, 1'b0, 20'd7040, 2'(i),
                                        16'(16'h4000 + i * 16'h3000), 20'd50, '0, 1'b0, '0));
    pending_items.push_back(make_item(OP_PLAY, KIND_NOISE, 1'b0, 20'd0, 2'd0, 16'h6000,
                                      20'd50, 32'hA5A5_0001, 1'b1, 16'd3));
    pending_items.push_back(make_item(OP_PLAY, KIND_TRIANGLE, 1'b0, 20'd3000, 2'd0, 16'h6000,
                                      20'd50, '0, 1'b0, '0));
    pending_items.push_back(make_item(OP_NONE, 2'd3, 1'b1, 20'hFFFFF, 2'd3, 16'hFFFF,
                                      20'hFFFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF));
    repeat (4)
      pending_items.push_back(make_item(OP_TICK, 2'd0, 1'b0, '0, '0, '0, '0, '0, 1'b0, '0));
    add_random(90);

    // sender held back until every sample has come out
    drain();
    no_gaps = 1'b1;
    add_random(100);
    drain();
    no_gaps = 1'b0;
    write_rates(18'd8000, 32'd536871);
    add_random(100);
    drain();
    write_rates(18'd192000, 32'd22370);
    add_random(100);
    drain();
    write_rates(18'd0, 32'hFFFF_FFFF);
    add_random(60);
    drain();
    write_rates(18'h3FFFF, 32'd0);
    add_random(60);
    drain();
    write_rates(18'd10, 32'd429496730);
    add_random(90);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
